[sv/spatial_hash_neighbour_cells_core_macros.svh]
// assertion macros for the spatial hash neighbour cells core
`ifndef SPATIAL_HASH_NEIGHBOUR_CELLS_CORE_MACROS_SVH
`define SPATIAL_HASH_NEIGHBOUR_CELLS_CORE_MACROS_SVH

// checked only outside reset
`define SHNC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked on every edge, reset included
`define SHNC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[sv/shnc_pkg.sv]
// types and constants shared by the spatial hash neighbour cells core
package shnc_pkg;

    localparam int unsigned POS_W      = 32;
    localparam int unsigned REACH_W    = 24;
    localparam int unsigned BKT_W      = 16;
    localparam int unsigned TSZ_W      = 17;
    localparam int unsigned CELL_W     = 32;
    localparam int unsigned NUM_LANES  = 9;
    localparam int unsigned DIV_W      = 34;
    localparam int unsigned DIV_CNT_W  = 6;
    localparam int unsigned MOD_CNT_W  = 5;
    localparam int unsigned NUM_MARKS  = 6;
    localparam int unsigned MAX_RES    = 11;
    localparam int unsigned LIST_W     = 4;
    localparam int unsigned STEP_W     = 4;
    localparam int unsigned PRIME_W    = 12;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);
    localparam logic [MOD_CNT_W-1:0] MOD_LAST = MOD_CNT_W'(CELL_W - 1);

    localparam logic [PRIME_W-1:0] PRIME_X = 12'd1319;
    localparam logic [PRIME_W-1:0] PRIME_Y = 12'd2083;
    localparam logic [PRIME_W-1:0] PRIME_Z = 12'd3169;

    // register indexes
    localparam logic [1:0] CFG_GRID = 2'd0;
    localparam logic [1:0] CFG_ADJ  = 2'd1;
    localparam logic [1:0] CFG_TSZ  = 2'd2;

    localparam logic [TSZ_W-1:0] TSZ_MAX = 17'd65536;

    // cell choice per axis: centre, plus (reach + adj), minus (reach + adj)
    localparam logic [1:0] SEL_C = 2'd0;
    localparam logic [1:0] SEL_P = 2'd1;
    localparam logic [1:0] SEL_M = 2'd2;

    // candidate order
    localparam logic [STEP_W-1:0] STEP_CENTRE = 4'd0;
    localparam logic [STEP_W-1:0] STEP_XP     = 4'd1;
    localparam logic [STEP_W-1:0] STEP_XM     = 4'd2;
    localparam logic [STEP_W-1:0] STEP_YP     = 4'd3;
    localparam logic [STEP_W-1:0] STEP_YM     = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ZP     = 4'd5;
    localparam logic [STEP_W-1:0] STEP_ZM     = 4'd6;
    localparam logic [STEP_W-1:0] STEP_XY     = 4'd7;
    localparam logic [STEP_W-1:0] STEP_CORNER = 4'd8;
    localparam logic [STEP_W-1:0] STEP_XZ     = 4'd9;
    localparam logic [STEP_W-1:0] STEP_YZ     = 4'd10;

    // mark bits
    localparam int unsigned MK_XP = 0;
    localparam int unsigned MK_XM = 1;
    localparam int unsigned MK_YP = 2;
    localparam int unsigned MK_YM = 3;
    localparam int unsigned MK_ZP = 4;
    localparam int unsigned MK_ZM = 5;

    typedef struct packed {
        logic                      action;
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [POS_W-1:0]   pos_z;
        logic [REACH_W-1:0]        reach;
    } t_in;

    typedef struct packed {
        logic [BKT_W-1:0] bucket;
        logic             last;
    } t_out;

    // lanes x centre, x plus, x minus, then y, then z
    typedef struct packed {
        logic                                action;
        logic [NUM_LANES-1:0][CELL_W-1:0]    cidx;
    } t_cells;

    typedef struct packed {
        logic [REACH_W-1:0] grid;
        logic [REACH_W-1:0] adj;
        logic [TSZ_W-1:0]   tsz;
    } t_cfg;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_SEL,
        BS_HASH,
        BS_MOD,
        BS_EMIT,
        BS_FLUSH
    } t_bstate;

endpackage

[sv/shnc_front.sv]
// front part: takes requests and turns positions into cell indices
module shnc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  shnc_pkg::t_in   i_item,
    input  shnc_pkg::t_cfg  i_cfg,
    input  logic            i_cq_full,
    output logic            o_cq_push,
    output shnc_pkg::t_cells o_cells
);
    import shnc_pkg::*;

    logic                    r_hold_vld;
    t_in                     r_hold;
    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_W-1:0]    r_cnt;
    logic                    r_act;
    logic [DIV_W-1:0]        r_num [NUM_LANES];
    logic [REACH_W-1:0]      r_rem [NUM_LANES];
    logic [NUM_LANES-1:0]    r_neg;

    logic                    w_start;
    logic [REACH_W:0]        w_dist;
    logic [POS_W-1:0]        w_pos [3];
    logic signed [DIV_W:0]   w_val [NUM_LANES];
    logic [DIV_W:0]          w_abs [NUM_LANES];
    logic [REACH_W:0]        w_pre [NUM_LANES];
    logic [REACH_W+1:0]      w_diff [NUM_LANES];
    logic [CELL_W-1:0]       w_q32 [NUM_LANES];

    assign o_full  = r_hold_vld;
    assign w_start = r_hold_vld && !r_busy && !r_done;
    assign w_dist  = {1'b0, r_hold.reach} + {1'b0, i_cfg.adj};
    assign w_pos[0] = r_hold.pos_x;
    assign w_pos[1] = r_hold.pos_y;
    assign w_pos[2] = r_hold.pos_z;

    // offset positions and their magnitudes
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_val[3*a]   = {{(DIV_W-POS_W+1){w_pos[a][POS_W-1]}}, w_pos[a]};
            w_val[3*a+1] = w_val[3*a] + $signed({{(DIV_W-REACH_W){1'b0}}, w_dist});
            w_val[3*a+2] = w_val[3*a] - $signed({{(DIV_W-REACH_W){1'b0}}, w_dist});
        end
        for (int l = 0; l < NUM_LANES; l++) begin
            w_abs[l] = w_val[l][DIV_W] ? ((DIV_W+1)'(0) - w_val[l]) : w_val[l];
        end
    end

    // one restoring division step per lane, and floor correction of the result
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            w_pre[l]  = {r_rem[l], r_num[l][DIV_W-1]};
            w_diff[l] = {1'b0, w_pre[l]} - {2'b0, i_cfg.grid};
            w_q32[l]  = r_num[l][CELL_W-1:0] + {{(CELL_W-1){1'b0}}, |r_rem[l]};
            o_cells.cidx[l] = r_neg[l] ? (CELL_W'(0) - w_q32[l]) : r_num[l][CELL_W-1:0];
        end
        o_cells.action = r_act;
    end

    assign o_cq_push = r_done && !i_cq_full;

    // holding register for the next request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
        end else if (i_push && !r_hold_vld) begin
            r_hold_vld <= 1'b1;
        end else if (w_start) begin
            r_hold_vld <= 1'b0;
        end
        if (i_push && !r_hold_vld) begin
            r_hold <= i_item;
        end
    end

    // divider control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (w_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else if (o_cq_push) begin
            r_done <= 1'b0;
        end
    end

    // divider lanes
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NUM_LANES; l++) begin
            if (w_start) begin
                r_num[l] <= w_abs[l][DIV_W-1:0];
                r_rem[l] <= '0;
                r_neg[l] <= w_val[l][DIV_W];
            end else if (r_busy) begin
                r_num[l] <= {r_num[l][DIV_W-2:0], !w_diff[l][REACH_W+1]};
                r_rem[l] <= w_diff[l][REACH_W+1] ? w_pre[l][REACH_W-1:0]
                                                 : w_diff[l][REACH_W-1:0];
            end
        end
        if (w_start) begin
            r_act <= r_hold.action;
        end
    end

endmodule

[sv/shnc_back.sv]
// back part: hashes candidate cells, drops repeats and queues the buckets
module shnc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cq_vld,
    input  shnc_pkg::t_cells i_cells,
    output logic             o_cq_pop,
    input  logic [shnc_pkg::TSZ_W-1:0] i_tsz,
    output logic             o_empty,
    input  logic             i_pop,
    output shnc_pkg::t_out   o_res
);
    import shnc_pkg::*;

    t_bstate              r_state, n_state;
    t_cells               r_cells, n_cells;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [NUM_MARKS-1:0] r_mark, n_mark;
    logic [BKT_W-1:0]     r_list [MAX_RES];
    logic [BKT_W-1:0]     n_list [MAX_RES];
    logic [LIST_W-1:0]    r_nlist, n_nlist;
    logic                 r_pend_vld, n_pend_vld;
    logic [BKT_W-1:0]     r_pend, n_pend;
    logic [1:0]           r_sx, n_sx, r_sy, n_sy, r_sz, n_sz;
    logic [CELL_W-1:0]    r_h, n_h;
    logic [1:0]           r_hcnt, n_hcnt;
    logic [CELL_W-1:0]    r_hsh, n_hsh;
    logic [BKT_W-1:0]     r_mrem, n_mrem;
    logic [MOD_CNT_W-1:0] r_mcnt, n_mcnt;

    t_out                 r_of [2];
    logic                 r_of_wp, r_of_rp;
    logic [1:0]           r_of_cnt;
    logic                 w_of_full, w_of_push, w_of_pop;
    t_out                 w_of_data;

    logic                 w_use;
    logic [1:0]           w_sx, w_sy, w_sz;
    logic                 w_xy_ok, w_xz_ok, w_yz_ok, w_cz_ok;
    logic [1:0]           w_xy_x, w_xy_y, w_cz, w_xz_x, w_xz_z, w_yz_y, w_yz_z;
    logic [3:0]           w_lane;
    logic [CELL_W-1:0]    w_opnd;
    logic [PRIME_W-1:0]   w_prime;
    logic [CELL_W+PRIME_W-1:0] w_prod;
    logic [BKT_W:0]       w_pre;
    logic                 w_ge;
    logic                 w_hit;

    // first marked pair on each plane and the z corner of the xy pair
    always_comb begin
        w_xy_ok = 1'b1; w_xy_x = SEL_P; w_xy_y = SEL_P;
        priority if (r_mark[MK_XP] && r_mark[MK_YP]) begin
            w_xy_x = SEL_P; w_xy_y = SEL_P;
        end else if (r_mark[MK_XM] && r_mark[MK_YP]) begin
            w_xy_x = SEL_M; w_xy_y = SEL_P;
        end else if (r_mark[MK_XP] && r_mark[MK_YM]) begin
            w_xy_x = SEL_P; w_xy_y = SEL_M;
        end else if (r_mark[MK_XM] && r_mark[MK_YM]) begin
            w_xy_x = SEL_M; w_xy_y = SEL_M;
        end else begin
            w_xy_ok = 1'b0;
        end
        w_cz_ok = r_mark[MK_ZP] || r_mark[MK_ZM];
        if (w_xy_x == SEL_P && w_xy_y == SEL_P) begin
            w_cz = r_mark[MK_ZP] ? SEL_P : SEL_M;
        end else begin
            w_cz = r_mark[MK_ZM] ? SEL_M : SEL_P;
        end
        w_xz_ok = 1'b1; w_xz_x = SEL_P; w_xz_z = SEL_P;
        priority if (r_mark[MK_XP] && r_mark[MK_ZP]) begin
            w_xz_x = SEL_P; w_xz_z = SEL_P;
        end else if (r_mark[MK_XM] && r_mark[MK_ZP]) begin
            w_xz_x = SEL_M; w_xz_z = SEL_P;
        end else if (r_mark[MK_XP] && r_mark[MK_ZM]) begin
            w_xz_x = SEL_P; w_xz_z = SEL_M;
        end else if (r_mark[MK_XM] && r_mark[MK_ZM]) begin
            w_xz_x = SEL_M; w_xz_z = SEL_M;
        end else begin
            w_xz_ok = 1'b0;
        end
        w_yz_ok = 1'b1; w_yz_y = SEL_P; w_yz_z = SEL_P;
        priority if (r_mark[MK_YP] && r_mark[MK_ZP]) begin
            w_yz_y = SEL_P; w_yz_z = SEL_P;
        end else if (r_mark[MK_YM] && r_mark[MK_ZP]) begin
            w_yz_y = SEL_M; w_yz_z = SEL_P;
        end else if (r_mark[MK_YP] && r_mark[MK_ZM]) begin
            w_yz_y = SEL_P; w_yz_z = SEL_M;
        end else if (r_mark[MK_YM] && r_mark[MK_ZM]) begin
            w_yz_y = SEL_M; w_yz_z = SEL_M;
        end else begin
            w_yz_ok = 1'b0;
        end
    end

    // candidate cell of the current step
    always_comb begin
        w_use = !r_cells.action;
        w_sx  = SEL_C; w_sy = SEL_C; w_sz = SEL_C;
        unique case (r_step)
            STEP_CENTRE: w_use = 1'b1;
            STEP_XP:     w_sx = SEL_P;
            STEP_XM:     w_sx = SEL_M;
            STEP_YP:     w_sy = SEL_P;
            STEP_YM:     w_sy = SEL_M;
            STEP_ZP:     w_sz = SEL_P;
            STEP_ZM:     w_sz = SEL_M;
            STEP_XY: begin
                w_use = !r_cells.action && w_xy_ok;
                w_sx  = w_xy_x; w_sy = w_xy_y;
            end
            STEP_CORNER: begin
                w_use = !r_cells.action && w_xy_ok && w_cz_ok;
                w_sx  = w_xy_x; w_sy = w_xy_y; w_sz = w_cz;
            end
            STEP_XZ: begin
                w_use = !r_cells.action && w_xz_ok;
                w_sx  = w_xz_x; w_sz = w_xz_z;
            end
            STEP_YZ: begin
                w_use = !r_cells.action && w_yz_ok;
                w_sy  = w_yz_y; w_sz = w_yz_z;
            end
            default: w_use = 1'b0;
        endcase
    end

    // one hash product per cycle, x then y then z
    always_comb begin
        unique case (r_hcnt)
            2'd0: begin
                w_lane = 4'd0 + {2'b0, r_sx}; w_prime = PRIME_X;
            end
            2'd1: begin
                w_lane = 4'd3 + {2'b0, r_sy}; w_prime = PRIME_Y;
            end
            2'd2: begin
                w_lane = 4'd6 + {2'b0, r_sz}; w_prime = PRIME_Z;
            end
            default: begin
                w_lane = 4'd0; w_prime = '0;
            end
        endcase
        w_opnd = r_cells.cidx[w_lane];
        w_prod = (CELL_W+PRIME_W)'(w_opnd) * (CELL_W+PRIME_W)'(w_prime);
    end

    // remainder step and repeat search
    assign w_pre = {r_mrem, r_hsh[CELL_W-1]};
    assign w_ge  = w_pre >= i_tsz;
    always_comb begin
        w_hit = 1'b0;
        for (int i = 0; i < MAX_RES; i++) begin
            if (LIST_W'(i) < r_nlist && r_list[i] == r_mrem) begin
                w_hit = 1'b1;
            end
        end
    end

    assign w_of_full = (r_of_cnt == 2'd2);
    assign w_of_pop  = i_pop && !o_empty;
    assign o_empty   = (r_of_cnt == 2'd0);
    assign o_res     = r_of[r_of_rp];

    // sequencer next state
    always_comb begin
        n_state    = r_state;
        n_cells    = r_cells;
        n_step     = r_step;
        n_mark     = r_mark;
        n_list     = r_list;
        n_nlist    = r_nlist;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        n_sx       = r_sx;
        n_sy       = r_sy;
        n_sz       = r_sz;
        n_h        = r_h;
        n_hcnt     = r_hcnt;
        n_hsh      = r_hsh;
        n_mrem     = r_mrem;
        n_mcnt     = r_mcnt;
        o_cq_pop   = 1'b0;
        w_of_push  = 1'b0;
        w_of_data  = '0;
        unique case (r_state)
            BS_IDLE: begin
                if (i_cq_vld) begin
                    o_cq_pop = 1'b1;
                    n_cells  = i_cells;
                    n_step   = STEP_CENTRE;
                    n_mark   = '0;
                    n_nlist  = '0;
                    n_state  = (i_tsz == '0) ? BS_IDLE : BS_SEL;
                end
            end
            BS_SEL: begin
                if (r_step > STEP_YZ) begin
                    n_state = BS_FLUSH;
                end else if (w_use) begin
                    n_sx    = w_sx;
                    n_sy    = w_sy;
                    n_sz    = w_sz;
                    n_h     = '0;
                    n_hcnt  = '0;
                    n_state = BS_HASH;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            BS_HASH: begin
                n_h    = r_h + w_prod[CELL_W-1:0];
                n_hcnt = r_hcnt + 1'b1;
                if (r_hcnt == 2'd2) begin
                    n_hsh   = r_h + w_prod[CELL_W-1:0];
                    n_mrem  = '0;
                    n_mcnt  = '0;
                    n_state = BS_MOD;
                end
            end
            BS_MOD: begin
                n_hsh  = {r_hsh[CELL_W-2:0], 1'b0};
                n_mrem = w_ge ? BKT_W'({1'b0, w_pre} - i_tsz) : w_pre[BKT_W-1:0];
                n_mcnt = r_mcnt + 1'b1;
                if (r_mcnt == MOD_LAST) begin
                    n_state = BS_EMIT;
                end
            end
            BS_EMIT: begin
                if (w_hit) begin
                    n_step  = r_step + 1'b1;
                    n_state = BS_SEL;
                end else if (!(r_pend_vld && w_of_full)) begin
                    // previous bucket is now known not to be the last one
                    w_of_push  = r_pend_vld;
                    w_of_data  = '{bucket: r_pend, last: 1'b0};
                    n_pend     = r_mrem;
                    n_pend_vld = 1'b1;
                    n_list[r_nlist] = r_mrem;
                    n_nlist    = r_nlist + 1'b1;
                    if (r_step >= STEP_XP && r_step <= STEP_ZM) begin
                        n_mark[r_step[2:0] - 3'd1] = 1'b1;
                    end
                    n_step  = r_step + 1'b1;
                    n_state = BS_SEL;
                end
            end
            BS_FLUSH: begin
                if (!r_pend_vld) begin
                    n_state = BS_IDLE;
                end else if (!w_of_full) begin
                    w_of_push  = 1'b1;
                    w_of_data  = '{bucket: r_pend, last: 1'b1};
                    n_pend_vld = 1'b0;
                    n_state    = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BS_IDLE;
            r_pend_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend_vld <= n_pend_vld;
        end
        r_cells <= n_cells;
        r_step  <= n_step;
        r_mark  <= n_mark;
        r_list  <= n_list;
        r_nlist <= n_nlist;
        r_pend  <= n_pend;
        r_sx    <= n_sx;
        r_sy    <= n_sy;
        r_sz    <= n_sz;
        r_h     <= n_h;
        r_hcnt  <= n_hcnt;
        r_hsh   <= n_hsh;
        r_mrem  <= n_mrem;
        r_mcnt  <= n_mcnt;
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_of_wp  <= 1'b0;
            r_of_rp  <= 1'b0;
            r_of_cnt <= '0;
        end else begin
            if (w_of_push) begin
                r_of_wp <= !r_of_wp;
            end
            if (w_of_pop) begin
                r_of_rp <= !r_of_rp;
            end
            r_of_cnt <= r_of_cnt + {1'b0, w_of_push} - {1'b0, w_of_pop};
        end
        if (w_of_push) begin
            r_of[r_of_wp] <= w_of_data;
        end
    end

endmodule

[sv/spatial_hash_neighbour_cells_core.sv]
// top level of the spatial hash neighbour cells core
//
//   channel   | handshake        | payload
//   ----------+------------------+-------------------------------
//   request   | push / full      | i_item  (action, pos_x/y/z, reach)
//   result    | pop / empty      | o_res   (bucket, last)
//   config    | i_cfg_we         | i_cfg_idx, i_cfg_wdata
//
// the front runs nine shift-subtract dividers in parallel on 34-bit magnitudes and can hold
// one more request while they run; the back hashes each candidate from x, y and z products
// and a remainder by the table size, skips unused steps, and for action 1 hashes only the centre
// a two-entry queue sits between front and back, and a two-entry queue on the result side
// a full result queue stalls the back, a full middle queue stalls the front
// reset is synchronous, clears control state and loads the configuration defaults
`include "spatial_hash_neighbour_cells_core_macros.svh"

module spatial_hash_neighbour_cells_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  shnc_pkg::t_in               i_item,
    output logic                        empty,
    input  logic                        pop,
    output shnc_pkg::t_out              o_res,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [shnc_pkg::REACH_W-1:0] i_cfg_wdata
);
    import shnc_pkg::*;

    logic [REACH_W-1:0] r_grid;
    logic [REACH_W-1:0] r_adj;
    logic [TSZ_W-1:0]   r_tsz;
    t_cfg               w_cfg;

    t_cells             r_q [2];
    logic               r_q_wp, r_q_rp;
    logic [1:0]         r_q_cnt;
    logic               w_cq_full, w_cq_vld, w_fr_push, w_cq_pop;
    t_cells             w_fr_cells;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid <= 24'd25600;
            r_adj  <= '0;
            r_tsz  <= 17'd1024;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID: r_grid <= i_cfg_wdata;
                CFG_ADJ:  r_adj  <= i_cfg_wdata;
                CFG_TSZ:  r_tsz  <= i_cfg_wdata[TSZ_W-1:0];
                default:  ;
            endcase
        end
    end

    // zero grid acts as one, table size saturates
    assign w_cfg.grid = (r_grid == '0) ? REACH_W'(1) : r_grid;
    assign w_cfg.adj  = r_adj;
    assign w_cfg.tsz  = (r_tsz > TSZ_MAX) ? TSZ_MAX : r_tsz;

    shnc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_item    (i_item),
        .i_cfg     (w_cfg),
        .i_cq_full (w_cq_full),
        .o_cq_push (w_fr_push),
        .o_cells   (w_fr_cells)
    );

    // queue between front and back
    assign w_cq_full = (r_q_cnt == 2'd2);
    assign w_cq_vld  = (r_q_cnt != 2'd0);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wp  <= 1'b0;
            r_q_rp  <= 1'b0;
            r_q_cnt <= '0;
        end else begin
            if (w_fr_push) begin
                r_q_wp <= !r_q_wp;
            end
            if (w_cq_pop) begin
                r_q_rp <= !r_q_rp;
            end
            r_q_cnt <= r_q_cnt + {1'b0, w_fr_push} - {1'b0, w_cq_pop};
        end
        if (w_fr_push) begin
            r_q[r_q_wp] <= w_fr_cells;
        end
    end

    shnc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cq_vld (w_cq_vld),
        .i_cells  (r_q[r_q_rp]),
        .o_cq_pop (w_cq_pop),
        .i_tsz    (w_cfg.tsz),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_res    (o_res)
    );

    // checks
    `SHNC_ASSERT_ALWAYS(a_full_clear_after_rst, !i_rst_n |=> !full, "full set after reset")
    `SHNC_ASSERT(a_push_fills_hold, push && !full |=> full, "request not held")
    `SHNC_ASSERT(a_mid_no_overflow, w_fr_push |-> !w_cq_full, "middle queue overflow")
    `SHNC_ASSERT(a_mid_no_underflow, w_cq_pop |-> w_cq_vld, "middle queue underflow")

endmodule
